FILE: hdl/fts_pkg.sv
// shared constants, codes and request/response types of the thread scheduler
`timescale 1ns / 1ps
`default_nettype none
package fts_pkg;

  localparam int unsigned MaxThreads = 16;
  localparam int unsigned IdW        = $clog2(MaxThreads);
  localparam int unsigned CntW       = $clog2(MaxThreads + 1);
  localparam int unsigned ValueW     = 32;

  typedef logic [IdW-1:0]    id_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [IdW:0]      waiter_t;
  typedef logic [ValueW-1:0] value_t;

  // waiter code that means nobody is joined
  localparam waiter_t NoWaiter = waiter_t'(MaxThreads);

  typedef enum logic [2:0] {
    TS_UNUSED   = 3'd0,
    TS_RUNNING  = 3'd1,
    TS_READY    = 3'd2,
    TS_BLOCKED  = 3'd3,
    TS_FINISHED = 3'd4
  } ts_e;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_YIELD  = 2'd1,
    OP_JOIN   = 2'd2,
    OP_EXIT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RS_SWITCHED = 2'd0,
    RS_RETURNED = 2'd1,
    RS_HALTED   = 2'd2,
    RS_FULL     = 2'd3
  } rs_e;

  // thread table port: one shared read address, one write port per array
  typedef struct packed {
    id_t     rd_addr;
    logic    st_we;
    id_t     st_addr;
    ts_e     st_data;
    logic    wt_we;
    id_t     wt_addr;
    waiter_t wt_data;
    logic    sv_we;
    id_t     sv_addr;
    value_t  sv_data;
  } tbl_req_t;

  typedef struct packed {
    ts_e     status;
    waiter_t waiter;
    value_t  value;
  } tbl_rsp_t;

  // ready queue port
  typedef struct packed {
    logic push;
    id_t  push_id;
    logic pop;
  } rq_req_t;

  typedef struct packed {
    logic empty;
    id_t  pop_id;
  } rq_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/fts_if.sv
// valid/ready channel interfaces for scheduler events and results
`timescale 1ns / 1ps
`default_nettype none
interface fts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  target_id;
  logic [31:0] exit_value;

  modport source (output valid, output op, output target_id, output exit_value, input ready);
  modport sink   (input valid, input op, input target_id, input exit_value, output ready);
endinterface

interface fts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  running_id;
  logic [3:0]  new_id;
  logic        value_valid;
  logic [31:0] result_value;
  logic        woken_valid;
  logic [3:0]  woken_id;

  modport source (output valid, output status, output running_id, output new_id,
                  output value_valid, output result_value, output woken_valid,
                  output woken_id, input ready);
  modport sink   (input valid, input status, input running_id, input new_id,
                  input value_valid, input result_value, input woken_valid,
                  input woken_id, output ready);
endinterface
`default_nettype wire

FILE: hdl/fts_table.sv
// per-thread table: status, join waiter and stored value memories
`timescale 1ns / 1ps
`default_nettype none
module fts_table
  import fts_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire tbl_req_t req_i,
  output tbl_rsp_t      rsp_o
);

  ts_e     st_mem [MaxThreads];
  waiter_t wt_mem [MaxThreads];
  value_t  sv_mem [MaxThreads];

  logic [MaxThreads-1:0] st_vld_q;
  logic [MaxThreads-1:0] wt_vld_q;

  ts_e     st_rd_q;
  waiter_t wt_rd_q;
  value_t  sv_rd_q;
  logic    st_rv_q;
  logic    wt_rv_q;
  logic    rd_zero_q;

  // valid bits, entries not yet written read as their reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
      wt_vld_q <= '0;
    end else begin
      if (req_i.st_we) st_vld_q[req_i.st_addr] <= 1'b1;
      if (req_i.wt_we) wt_vld_q[req_i.wt_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.st_we) st_mem[req_i.st_addr] <= req_i.st_data;
    if (req_i.wt_we) wt_mem[req_i.wt_addr] <= req_i.wt_data;
    if (req_i.sv_we) sv_mem[req_i.sv_addr] <= req_i.sv_data;
    st_rd_q   <= st_mem[req_i.rd_addr];
    wt_rd_q   <= wt_mem[req_i.rd_addr];
    sv_rd_q   <= sv_mem[req_i.rd_addr];
    st_rv_q   <= st_vld_q[req_i.rd_addr];
    wt_rv_q   <= wt_vld_q[req_i.rd_addr];
    rd_zero_q <= (req_i.rd_addr == '0);
  end

  always_comb begin
    rsp_o.value  = sv_rd_q;
    rsp_o.waiter = wt_rv_q ? wt_rd_q : NoWaiter;
    if (st_rv_q) begin
      rsp_o.status = st_rd_q;
    end else begin
      rsp_o.status = rd_zero_q ? TS_RUNNING : TS_UNUSED;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/fts_queue.sv
// ready queue: circular id memory with head, tail and count
`timescale 1ns / 1ps
`default_nettype none
module fts_queue
  import fts_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire rq_req_t req_i,
  output rq_rsp_t      rsp_o
);

  id_t  fifo_mem [MaxThreads];
  id_t  head_q, head_d;
  id_t  tail_q, tail_d;
  cnt_t count_q, count_d;
  id_t  pop_id_q;
  logic full;
  logic do_push;
  logic do_pop;

  assign full    = (count_q == cnt_t'(MaxThreads));
  assign do_push = req_i.push && !full;
  assign do_pop  = req_i.pop && (count_q != '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (do_push) begin
      tail_d = (tail_q == id_t'(MaxThreads - 1)) ? '0 : tail_q + id_t'(1);
    end
    if (do_pop) begin
      head_d = (head_q == id_t'(MaxThreads - 1)) ? '0 : head_q + id_t'(1);
    end
    if (do_push && !do_pop) count_d = count_q + cnt_t'(1);
    if (do_pop && !do_push) count_d = count_q - cnt_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) fifo_mem[tail_q] <= req_i.push_id;
    if (do_pop)  pop_id_q <= fifo_mem[head_q];
  end

  assign rsp_o.empty  = (count_q == '0);
  assign rsp_o.pop_id = pop_id_q;

endmodule
`default_nettype wire

FILE: hdl/fifo_thread_scheduler.sv
// top level: cooperative thread scheduler with a fifo ready queue
//
//   channel  modport            word carries
//   in_i     fts_in_if.sink     op, target_id, exit_value
//   out_o    fts_out_if.source  status, running_id, new_id, value_valid,
//                               result_value, woken_valid, woken_id
//
// an event that needs no table or queue read is settled in S_EXEC (halted,
// table full, yield with empty queue, join on self); a join that returns goes
// through S_JOIN_RD; a switch ends with S_POP and S_SWITCH, after S_PUSH_CUR,
// S_JOIN_RD or S_EXIT_RD for a create, join or exit, and a halt ends in S_POP;
// the registered reads of the thread table and the queue memory set these paths.
// no clearing pass after reset: status and waiter entries carry valid bits.
// a new event is taken while the last result still waits in the output
// register; the result of that event then holds in the done state until the
// output register frees up.
`timescale 1ns / 1ps
`default_nettype none
module fifo_thread_scheduler
  import fts_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fts_in_if.sink     in_i,
  fts_out_if.source  out_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_EXEC     = 8'b0000_0010,
    S_JOIN_RD  = 8'b0000_0100,
    S_EXIT_RD  = 8'b0000_1000,
    S_PUSH_CUR = 8'b0001_0000,
    S_POP      = 8'b0010_0000,
    S_SWITCH   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e  state_q, state_d;

  // captured event
  op_e     op_q, op_d;
  id_t     target_q, target_d;
  value_t  xval_q, xval_d;

  // scheduler registers
  id_t     cur_q, cur_d;
  cnt_t    nf_q, nf_d;
  logic    halted_q, halted_d;

  // result being built
  rs_e     rs_q, rs_d;
  id_t     new_id_q, new_id_d;
  logic    vvalid_q, vvalid_d;
  value_t  rvalue_q, rvalue_d;
  logic    wvalid_q, wvalid_d;
  id_t     wid_q, wid_d;

  // output register
  logic    ov_q, ov_d;
  rs_e     o_rs_q, o_rs_d;
  id_t     o_run_q, o_run_d;
  id_t     o_new_q, o_new_d;
  logic    o_vv_q, o_vv_d;
  value_t  o_rv_q, o_rv_d;
  logic    o_wv_q, o_wv_d;
  id_t     o_wid_q, o_wid_d;

  tbl_req_t tbl_req;
  tbl_rsp_t tbl_rsp;
  rq_req_t  rq_req;
  rq_rsp_t  rq_rsp;

  logic    in_fire;
  logic    out_free;

  fts_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  fts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rq_req),
    .rsp_o  (rq_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    target_d = target_q;
    xval_d   = xval_q;
    cur_d    = cur_q;
    nf_d     = nf_q;
    halted_d = halted_q;
    rs_d     = rs_q;
    new_id_d = new_id_q;
    vvalid_d = vvalid_q;
    rvalue_d = rvalue_q;
    wvalid_d = wvalid_q;
    wid_d    = wid_q;

    ov_d     = ov_q && !out_o.ready;
    o_rs_d   = o_rs_q;
    o_run_d  = o_run_q;
    o_new_d  = o_new_q;
    o_vv_d   = o_vv_q;
    o_rv_d   = o_rv_q;
    o_wv_d   = o_wv_q;
    o_wid_d  = o_wid_q;

    tbl_req  = '0;
    tbl_req.rd_addr = cur_q;
    rq_req   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d     = op_e'(in_i.op);
          target_d = id_t'(in_i.target_id);
          xval_d   = value_t'(in_i.exit_value);
          rs_d     = RS_RETURNED;
          new_id_d = '0;
          vvalid_d = 1'b0;
          rvalue_d = '0;
          wvalid_d = 1'b0;
          wid_d    = '0;
          state_d  = S_EXEC;
        end
      end

      S_EXEC: begin
        if (halted_q) begin
          rs_d    = RS_HALTED;
          state_d = S_DONE;
        end else begin
          unique case (op_q)
            OP_CREATE: begin
              if (nf_q >= cnt_t'(MaxThreads)) begin
                rs_d    = RS_FULL;
                state_d = S_DONE;
              end else begin
                // new thread enters the queue ahead of its creator
                tbl_req.st_we   = 1'b1;
                tbl_req.st_addr = nf_q[IdW-1:0];
                tbl_req.st_data = TS_READY;
                tbl_req.wt_we   = 1'b1;
                tbl_req.wt_addr = nf_q[IdW-1:0];
                tbl_req.wt_data = NoWaiter;
                rq_req.push     = 1'b1;
                rq_req.push_id  = nf_q[IdW-1:0];
                new_id_d        = nf_q[IdW-1:0];
                nf_d            = nf_q + cnt_t'(1);
                state_d         = S_PUSH_CUR;
              end
            end
            OP_YIELD: begin
              if (rq_rsp.empty) begin
                state_d = S_DONE;
              end else begin
                tbl_req.st_we   = 1'b1;
                tbl_req.st_addr = cur_q;
                tbl_req.st_data = TS_READY;
                rq_req.push     = 1'b1;
                rq_req.push_id  = cur_q;
                state_d         = S_POP;
              end
            end
            OP_JOIN: begin
              if (target_q == cur_q ||
                  {1'b0, target_q} >= (IdW + 1)'(MaxThreads)) begin
                state_d = S_DONE;
              end else begin
                tbl_req.rd_addr = target_q;
                state_d         = S_JOIN_RD;
              end
            end
            OP_EXIT: begin
              // waiter of the exiting thread is read while it is marked finished
              tbl_req.rd_addr = cur_q;
              tbl_req.st_we   = 1'b1;
              tbl_req.st_addr = cur_q;
              tbl_req.st_data = TS_FINISHED;
              tbl_req.sv_we   = 1'b1;
              tbl_req.sv_addr = cur_q;
              tbl_req.sv_data = xval_q;
              state_d         = S_EXIT_RD;
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_JOIN_RD: begin
        if (tbl_rsp.status == TS_UNUSED) begin
          state_d = S_DONE;
        end else if (tbl_rsp.status == TS_FINISHED) begin
          vvalid_d = 1'b1;
          rvalue_d = tbl_rsp.value;
          state_d  = S_DONE;
        end else begin
          // caller blocks and replaces any earlier waiter
          tbl_req.st_we   = 1'b1;
          tbl_req.st_addr = cur_q;
          tbl_req.st_data = TS_BLOCKED;
          tbl_req.wt_we   = 1'b1;
          tbl_req.wt_addr = target_q;
          tbl_req.wt_data = {1'b0, cur_q};
          state_d         = S_POP;
        end
      end

      S_EXIT_RD: begin
        if (tbl_rsp.waiter != NoWaiter) begin
          tbl_req.st_we   = 1'b1;
          tbl_req.st_addr = tbl_rsp.waiter[IdW-1:0];
          tbl_req.st_data = TS_READY;
          tbl_req.wt_we   = 1'b1;
          tbl_req.wt_addr = cur_q;
          tbl_req.wt_data = NoWaiter;
          rq_req.push     = 1'b1;
          rq_req.push_id  = tbl_rsp.waiter[IdW-1:0];
          wvalid_d        = 1'b1;
          wid_d           = tbl_rsp.waiter[IdW-1:0];
          vvalid_d        = 1'b1;
          rvalue_d        = xval_q;
        end
        state_d = S_POP;
      end

      S_PUSH_CUR: begin
        tbl_req.st_we   = 1'b1;
        tbl_req.st_addr = cur_q;
        tbl_req.st_data = TS_READY;
        rq_req.push     = 1'b1;
        rq_req.push_id  = cur_q;
        state_d         = S_POP;
      end

      S_POP: begin
        if (rq_rsp.empty) begin
          // nothing runnable: freeze with the blocked or finished thread
          halted_d = 1'b1;
          rs_d     = RS_HALTED;
          state_d  = S_DONE;
        end else begin
          rq_req.pop = 1'b1;
          state_d    = S_SWITCH;
        end
      end

      S_SWITCH: begin
        tbl_req.st_we   = 1'b1;
        tbl_req.st_addr = rq_rsp.pop_id;
        tbl_req.st_data = TS_RUNNING;
        cur_d           = rq_rsp.pop_id;
        rs_d            = RS_SWITCHED;
        state_d         = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          o_rs_d  = rs_q;
          o_run_d = cur_q;
          o_new_d = new_id_q;
          o_vv_d  = vvalid_q;
          o_rv_d  = rvalue_q;
          o_wv_d  = wvalid_q;
          o_wid_d = wid_q;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cur_q    <= '0;
      nf_q     <= cnt_t'(1);
      halted_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      nf_q     <= nf_d;
      halted_q <= halted_d;
      ov_q     <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    target_q <= target_d;
    xval_q   <= xval_d;
    rs_q     <= rs_d;
    new_id_q <= new_id_d;
    vvalid_q <= vvalid_d;
    rvalue_q <= rvalue_d;
    wvalid_q <= wvalid_d;
    wid_q    <= wid_d;
    o_rs_q   <= o_rs_d;
    o_run_q  <= o_run_d;
    o_new_q  <= o_new_d;
    o_vv_q   <= o_vv_d;
    o_rv_q   <= o_rv_d;
    o_wv_q   <= o_wv_d;
    o_wid_q  <= o_wid_d;
  end

  assign out_o.valid        = ov_q;
  assign out_o.status       = o_rs_q;
  assign out_o.running_id   = 4'(o_run_q);
  assign out_o.new_id       = 4'(o_new_q);
  assign out_o.value_valid  = o_vv_q;
  assign out_o.result_value = 32'(o_rv_q);
  assign out_o.woken_valid  = o_wv_q;
  assign out_o.woken_id     = 4'(o_wid_q);

endmodule
`default_nettype wire
